[rtl/bdsh_pkg.sv]
// ----------------------------------------------------------------------------
// bdsh_pkg
// Shared constants for the bloom-filter deduplicator with size histogram:
// field widths, stream data layout and default filter size.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsh_pkg;

    localparam int FILTER_INDEX_BITS_DEF = 24;

    localparam int NUM_WINDOWS = 17;
    localparam int NUM_BUCKETS = 32;
    localparam int BUCKET_W    = 5;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int SIZE_W      = 32;
    localparam int HASH_W      = 160;
    localparam int WORD_W      = 64;
    localparam int BIT_SEL_W   = 6;
    localparam int IDX_W       = 5;

    // item kind carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // input tdata layout
    localparam int IN_HASH_LSB = 0;
    localparam int IN_SIZE_LSB = 160;
    localparam int IN_SEL_LSB  = 192;
    localparam int IN_TDATA_W  = 200;

    // output tdata layout
    localparam int OUT_BUCKET_LSB = 0;
    localparam int OUT_UC_LSB     = 5;
    localparam int OUT_UB_LSB     = 37;
    localparam int OUT_TC_LSB     = 101;
    localparam int OUT_TB_LSB     = 133;
    localparam int OUT_TDATA_W    = 200;

    // counter memory word: {total_bytes, total_count, unique_bytes, unique_count}
    localparam int CNT_WORD_W = 2 * CNT_W + 2 * SUM_W;

endpackage

`default_nettype wire

[rtl/bdsh_ram.sv]
// ----------------------------------------------------------------------------
// bdsh_ram
// Generic single-write, single-read synchronous RAM with registered read
// data (read-old on a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module bdsh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/bloom_dedup_size_histogram.sv]
// ----------------------------------------------------------------------------
// bloom_dedup_size_histogram
// Bloom-filter deduplicator of object hashes with per-size-bucket counters.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 2^(FILTER_INDEX_BITS-6) words of the filter
// memory to zero, one 64-bit word a cycle, with s_tready low. It then works on
// one item at a time through the single port pair of the filter memory: an
// insert reads the seventeen window words, and if any bit was clear reads them
// again and writes each back with its bit set, then updates the bucket
// counters in a second memory and returns to idle. A counter read goes from
// ST_CWAIT to ST_CNT. The result waits in an output register, so the next
// item is taken while it is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_dedup_size_histogram #(
    parameter int FILTER_INDEX_BITS = bdsh_pkg::FILTER_INDEX_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // hash_bytes_0_7, hash_bytes_8_15, hash_bytes_16_19, object_size,
    // bucket_select, zero pad
    input  wire logic [bdsh_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tuser,  // mode
    input  wire logic                             s_tlast,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // bucket, unique_count, unique_bytes, total_count, total_bytes, zero pad
    output logic      [bdsh_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                  m_tuser,  // was_new
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready
);

    localparam int FW       = FILTER_INDEX_BITS - bdsh_pkg::BIT_SEL_W;
    localparam int FDEPTH   = 2 ** FW;
    localparam logic [bdsh_pkg::IDX_W-1:0] IDX_LAST = bdsh_pkg::IDX_W'(bdsh_pkg::NUM_WINDOWS);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_TEST  = 6'b000100,
        ST_SET   = 6'b001000,
        ST_CWAIT = 6'b010000,
        ST_CNT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [FW-1:0]                      clr_addr_reg, clr_addr_next;
    logic [bdsh_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [bdsh_pkg::HASH_W-1:0]        hash_reg;
    logic [bdsh_pkg::SIZE_W-1:0]        size_reg;
    logic [bdsh_pkg::BUCKET_W-1:0]      bucket_reg;
    logic                               mode_reg;
    logic                               last_reg;
    logic                               new_reg, new_next;
    logic                               pend_valid_reg;
    logic [FW-1:0]                      pend_addr_reg;
    logic [bdsh_pkg::BIT_SEL_W-1:0]     pend_bit_reg;
    logic                               wr_valid_reg;
    logic [FW-1:0]                      wr_addr_reg;
    logic [bdsh_pkg::WORD_W-1:0]        wr_data_reg;
    logic [bdsh_pkg::NUM_BUCKETS-1:0]   cnt_valid_reg;

    logic                               out_valid_reg;
    logic [bdsh_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                               out_new_reg;
    logic                               out_last_reg;
    logic [bdsh_pkg::OUT_TDATA_W-1:0]   out_word;

    // input side
    logic                               s_accept;
    logic [bdsh_pkg::SIZE_W-1:0]        in_size;
    logic [bdsh_pkg::BUCKET_W-1:0]      size_bkt;

    // filter memory
    logic                               filt_we;
    logic [FW-1:0]                      filt_waddr;
    logic [bdsh_pkg::WORD_W-1:0]        filt_wdata;
    logic [FW-1:0]                      filt_raddr;
    logic [bdsh_pkg::WORD_W-1:0]        filt_rdata;
    logic [bdsh_pkg::WORD_W-1:0]        word_fwd;
    logic [bdsh_pkg::HASH_W-1:0]        hash_shift;
    logic [bdsh_pkg::SIZE_W-1:0]        window;
    logic                               issue;
    logic                               test_miss;

    // counter memory
    logic                               cnt_we;
    logic [bdsh_pkg::CNT_WORD_W-1:0]    cnt_rdata;
    logic [bdsh_pkg::CNT_WORD_W-1:0]    cnt_cur;
    logic [bdsh_pkg::CNT_WORD_W-1:0]    cnt_new;
    logic [bdsh_pkg::CNT_W-1:0]         uc_cur, tc_cur, uc_new, tc_new;
    logic [bdsh_pkg::SUM_W-1:0]         ub_cur, tb_cur, ub_new, tb_new;
    logic [bdsh_pkg::SUM_W-1:0]         size_ext;
    logic                               out_free;
    logic                               finish;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_size  = s_tdata[bdsh_pkg::IN_SIZE_LSB +: bdsh_pkg::SIZE_W];

    // floor(log2 size), zero for sizes 0 and 1
    always_comb begin
        size_bkt = '0;
        for (int i = 1; i < bdsh_pkg::SIZE_W; i++) begin
            if (in_size[i]) begin
                size_bkt = bdsh_pkg::BUCKET_W'(i);
            end
        end
    end

    // window i is hash bytes i..i+3, little-endian
    assign hash_shift = hash_reg >> {idx_reg, 3'b000};
    assign window     = hash_shift[bdsh_pkg::SIZE_W-1:0];
    assign issue      = ((state_reg == ST_TEST) || (state_reg == ST_SET)) && (idx_reg != IDX_LAST);
    assign filt_raddr = window[FILTER_INDEX_BITS-1:bdsh_pkg::BIT_SEL_W];

    // take the word just written when the returning read hit the same address
    assign word_fwd  = (wr_valid_reg && (wr_addr_reg == pend_addr_reg)) ? wr_data_reg : filt_rdata;
    assign test_miss = pend_valid_reg && !word_fwd[pend_bit_reg];

    always_comb begin
        filt_we    = 1'b0;
        filt_waddr = pend_addr_reg;
        filt_wdata = word_fwd | (bdsh_pkg::WORD_W'(1) << pend_bit_reg);
        case (state_reg)
            ST_CLEAR: begin
                filt_we    = 1'b1;
                filt_waddr = clr_addr_reg;
                filt_wdata = '0;
            end
            ST_SET: begin
                filt_we = pend_valid_reg;
            end
            default: begin
                filt_we = 1'b0;
            end
        endcase
    end

    bdsh_ram #(
        .WIDTH (bdsh_pkg::WORD_W),
        .DEPTH (FDEPTH)
    ) u_filter_ram (
        .aclk  (aclk),
        .we    (filt_we),
        .waddr (filt_waddr),
        .wdata (filt_wdata),
        .raddr (filt_raddr),
        .rdata (filt_rdata)
    );

    // counters: entries never written read as zero
    assign cnt_cur  = cnt_valid_reg[bucket_reg] ? cnt_rdata : '0;
    assign uc_cur   = cnt_cur[0 +: bdsh_pkg::CNT_W];
    assign ub_cur   = cnt_cur[bdsh_pkg::CNT_W +: bdsh_pkg::SUM_W];
    assign tc_cur   = cnt_cur[bdsh_pkg::CNT_W + bdsh_pkg::SUM_W +: bdsh_pkg::CNT_W];
    assign tb_cur   = cnt_cur[2 * bdsh_pkg::CNT_W + bdsh_pkg::SUM_W +: bdsh_pkg::SUM_W];
    assign size_ext = bdsh_pkg::SUM_W'(size_reg);

    always_comb begin
        uc_new = uc_cur;
        ub_new = ub_cur;
        tc_new = tc_cur;
        tb_new = tb_cur;
        if (mode_reg == bdsh_pkg::MODE_INSERT) begin
            tc_new = tc_cur + bdsh_pkg::CNT_W'(1);
            tb_new = tb_cur + size_ext;
            if (new_reg) begin
                uc_new = uc_cur + bdsh_pkg::CNT_W'(1);
                ub_new = ub_cur + size_ext;
            end
        end
    end

    assign cnt_new  = {tb_new, tc_new, ub_new, uc_new};
    assign out_free = !out_valid_reg || m_tready;
    assign finish   = (state_reg == ST_CNT) && out_free;
    assign cnt_we   = finish && (mode_reg == bdsh_pkg::MODE_INSERT);

    bdsh_ram #(
        .WIDTH (bdsh_pkg::CNT_WORD_W),
        .DEPTH (bdsh_pkg::NUM_BUCKETS)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (bucket_reg),
        .wdata (cnt_new),
        .raddr (bucket_reg),
        .rdata (cnt_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        new_next      = new_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + FW'(1);
                if (clr_addr_reg == {FW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                idx_next = '0;
                if (s_accept) begin
                    new_next   = 1'b0;
                    state_next = (s_tuser == bdsh_pkg::MODE_READ) ? ST_CWAIT : ST_TEST;
                end
            end
            ST_TEST: begin
                new_next = new_reg || test_miss;
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = (new_reg || test_miss) ? ST_SET : ST_CNT;
                end else begin
                    idx_next = idx_reg + bdsh_pkg::IDX_W'(1);
                end
            end
            ST_SET: begin
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_CNT;
                end else begin
                    idx_next = idx_reg + bdsh_pkg::IDX_W'(1);
                end
            end
            ST_CWAIT: begin
                state_next = ST_CNT;
            end
            ST_CNT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // result word, pad bits zero
    always_comb begin
        out_word = '0;
        out_word[bdsh_pkg::OUT_BUCKET_LSB +: bdsh_pkg::BUCKET_W] = bucket_reg;
        out_word[bdsh_pkg::OUT_UC_LSB +: bdsh_pkg::CNT_W]        = uc_new;
        out_word[bdsh_pkg::OUT_UB_LSB +: bdsh_pkg::SUM_W]        = ub_new;
        out_word[bdsh_pkg::OUT_TC_LSB +: bdsh_pkg::CNT_W]        = tc_new;
        out_word[bdsh_pkg::OUT_TB_LSB +: bdsh_pkg::SUM_W]        = tb_new;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            idx_reg        <= '0;
            new_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            wr_valid_reg   <= 1'b0;
            cnt_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            idx_reg        <= idx_next;
            new_reg        <= new_next;
            pend_valid_reg <= issue;
            wr_valid_reg   <= filt_we;
            if (cnt_we) begin
                cnt_valid_reg[bucket_reg] <= 1'b1;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hash_reg   <= s_tdata[bdsh_pkg::IN_HASH_LSB +: bdsh_pkg::HASH_W];
            size_reg   <= in_size;
            mode_reg   <= s_tuser;
            last_reg   <= s_tlast;
            bucket_reg <= (s_tuser == bdsh_pkg::MODE_READ)
                          ? s_tdata[bdsh_pkg::IN_SEL_LSB +: bdsh_pkg::BUCKET_W]
                          : size_bkt;
        end
        pend_addr_reg <= filt_raddr;
        pend_bit_reg  <= window[bdsh_pkg::BIT_SEL_W-1:0];
        wr_addr_reg   <= filt_waddr;
        wr_data_reg   <= filt_wdata;
        if (finish) begin
            out_data_reg <= out_word;
            out_new_reg  <= new_reg && (mode_reg == bdsh_pkg::MODE_INSERT);
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_new_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/bdsh_checker.sv]
// ----------------------------------------------------------------------------
// bdsh_assert
// Port-level checks for the deduplicator: sweep after reset, one item in
// flight, no instant result, held output while stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsh_assert (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [bdsh_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tuser,
    input wire logic                             m_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready
);

    // the filter sweep keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> (!s_tready && !m_tvalid))
        else $error("input open or result pending right after reset");

    // one item at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in progress");

    // no result can come out of an item the cycle after it was taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result raised one cycle after accept");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed or dropped");

endmodule

bind bloom_dedup_size_histogram bdsh_assert u_bdsh_assert (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
